// ===== rtl/mdf_pkg.sv =====
// Package for the mono display frame store: operation codes, refresh
// header codes, command bytes and the controller/datapath link structs.
// No dependencies.
package mdf_pkg;

    typedef logic [2:0] t_op;

    localparam t_op OP_POINT   = 3'd0;
    localparam t_op OP_FILL    = 3'd1;
    localparam t_op OP_CLEAR   = 3'd2;
    localparam t_op OP_REFRESH = 3'd3;
    localparam t_op OP_PULL    = 3'd4;

    typedef logic [1:0] t_hdr;

    localparam t_hdr HDR_PAGE   = 2'd0;
    localparam t_hdr HDR_COL_LO = 2'd1;
    localparam t_hdr HDR_COL_HI = 2'd2;
    localparam t_hdr HDR_DATA   = 2'd3;

    localparam logic [7:0] CMD_PAGE_BASE = 8'hb0;
    localparam logic [7:0] CMD_COL_LOW   = 8'h00;
    localparam logic [7:0] CMD_COL_HIGH  = 8'h10;

    typedef struct packed {
        logic load;
        logic start_refresh;
        logic clr_start;
        logic clr_wr;
        logic fill_rd;
        logic fill_wr;
        logic pull_rd;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic box_empty;
        logic fill_last;
        logic clr_last;
        logic refresh_active;
        logic hdr_data;
        logic out_free;
    } t_sts;

endpackage

// ===== rtl/mdf_ctrl.sv =====
// Controller state machine of the mono display frame store.
// Depends on mdf_pkg; drives commands to mdf_datapath and reads its status.
module mdf_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  mdf_pkg::t_op   i_operation,
    input  mdf_pkg::t_sts  i_sts,
    output mdf_pkg::t_cmd  o_cmd
);
    import mdf_pkg::*;

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_RD    = 3'd2;
    localparam logic [2:0] S_WR    = 3'd3;
    localparam logic [2:0] S_PULL  = 3'd4;
    localparam logic [2:0] S_PDAT  = 3'd5;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic       accept;

    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = i_in_valid && o_in_ready;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clr_wr = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    o_cmd.load = 1'b1;
                    case (i_operation)
                        OP_POINT: begin
                            if (!i_sts.box_empty) begin
                                n_state = S_RD;
                            end
                        end
                        OP_FILL: begin
                            o_cmd.start_refresh = 1'b1;
                            if (!i_sts.box_empty) begin
                                n_state = S_RD;
                            end
                        end
                        OP_CLEAR: begin
                            o_cmd.start_refresh = 1'b1;
                            o_cmd.clr_start     = 1'b1;
                            n_state             = S_CLEAR;
                        end
                        OP_REFRESH: begin
                            o_cmd.start_refresh = 1'b1;
                        end
                        OP_PULL: begin
                            if (i_sts.refresh_active) begin
                                n_state = S_PULL;
                            end
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_RD: begin
                o_cmd.fill_rd = 1'b1;
                n_state       = S_WR;
            end
            S_WR: begin
                o_cmd.fill_wr = 1'b1;
                n_state       = i_sts.fill_last ? S_IDLE : S_RD;
            end
            S_PULL: begin
                if (i_sts.hdr_data) begin
                    o_cmd.pull_rd = 1'b1;
                    n_state       = S_PDAT;
                end else if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            S_PDAT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit |-> i_sts.out_free)
        else $error("item emitted into a full output register");

    a_pdat_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PDAT) |-> ($past(r_state) == S_PULL || $past(r_state) == S_PDAT))
        else $error("data emit state entered without a store read");

    a_wr_after_rd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WR) |-> ($past(r_state) == S_RD))
        else $error("store write without preceding read");

endmodule

// ===== rtl/mdf_datapath.sv =====
// Datapath of the mono display frame store: frame memory, box walk counters,
// refresh stream counters and the output register.
// Depends on mdf_pkg; driven by mdf_ctrl.
module mdf_datapath #(
    parameter int COLUMNS = 128,
    parameter int PAGES   = 8
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  mdf_pkg::t_cmd  i_cmd,
    output mdf_pkg::t_sts  o_sts,
    input  mdf_pkg::t_op   i_operation,
    input  logic [7:0]     i_x,
    input  logic [7:0]     i_y,
    input  logic [7:0]     i_x_end,
    input  logic [7:0]     i_y_end,
    input  logic           i_pixel_on,
    input  logic           i_out_ready,
    output logic           o_out_valid,
    output logic           o_is_command,
    output logic [7:0]     o_byte_value,
    output logic           o_frame_end
);
    import mdf_pkg::*;

    localparam int ROWS  = PAGES * 8;
    localparam int DEPTH = COLUMNS * PAGES;
    localparam int CW    = $clog2(COLUMNS);
    localparam int RW    = $clog2(ROWS);
    localparam int PW    = (PAGES > 1) ? $clog2(PAGES) : 1;
    localparam int GRW   = PW + 3;
    localparam int AW    = $clog2(DEPTH);

    localparam logic [8:0]    COL_MAX9 = 9'(COLUMNS - 1);
    localparam logic [8:0]    ROW_MAX9 = 9'(ROWS - 1);
    localparam logic [AW-1:0] COLS_A   = AW'(COLUMNS);
    localparam logic [AW-1:0] ADDR_MAX = AW'(DEPTH - 1);
    localparam logic [PW-1:0] PAGE_MAX = PW'(PAGES - 1);
    localparam logic [CW-1:0] COL_MAX  = CW'(COLUMNS - 1);

    logic [7:0]     mem [DEPTH];
    logic [7:0]     r_mem_q;

    logic [CW-1:0]  r_x0, r_x1, r_col;
    logic [RW-1:0]  r_y0, r_y1;
    logic [PW-1:0]  r_grp, r_g1;
    logic           r_on;
    logic [AW-1:0]  r_clr_addr;

    logic           r_active;
    logic [PW-1:0]  r_page;
    t_hdr           r_hdr;
    logic [CW-1:0]  r_rcol;

    logic           r_out_valid;
    logic           r_out_cmd;
    logic [7:0]     r_out_byte;
    logic           r_out_end;

    logic [7:0]     eff_xe, eff_ye;
    logic [8:0]     xe_c9, ye_c9;
    logic [PW-1:0]  fill_page;
    logic [AW-1:0]  fill_addr, ref_addr, wr_addr, rd_addr;
    logic [7:0]     fill_mask, n_wdata, wr_data;
    logic [GRW-1:0] row_k;
    logic           wr_en, rd_en;
    logic           rcol_last, page_last;
    logic           n_out_cmd, n_out_end;
    logic [7:0]     n_out_byte;

    assign eff_xe = (i_operation == OP_POINT) ? i_x : i_x_end;
    assign eff_ye = (i_operation == OP_POINT) ? i_y : i_y_end;
    assign xe_c9  = ({1'b0, eff_xe} > COL_MAX9) ? COL_MAX9 : {1'b0, eff_xe};
    assign ye_c9  = ({1'b0, eff_ye} > ROW_MAX9) ? ROW_MAX9 : {1'b0, eff_ye};

    assign fill_page = PAGE_MAX - r_grp;
    assign fill_addr = AW'(fill_page) * COLS_A + AW'(r_col);
    assign ref_addr  = AW'(r_page) * COLS_A + AW'(r_rcol);

    always_comb begin
        row_k     = '0;
        fill_mask = '0;
        for (int k = 0; k < 8; k++) begin
            row_k = {r_grp, 3'(k)};
            fill_mask[7-k] = (row_k >= GRW'(r_y0)) && (row_k <= GRW'(r_y1));
        end
    end

    assign n_wdata = r_on ? (r_mem_q | fill_mask) : (r_mem_q & ~fill_mask);

    assign wr_en   = i_cmd.clr_wr || i_cmd.fill_wr;
    assign wr_addr = i_cmd.clr_wr ? r_clr_addr : fill_addr;
    assign wr_data = i_cmd.clr_wr ? 8'h00 : n_wdata;
    assign rd_en   = i_cmd.fill_rd || i_cmd.pull_rd;
    assign rd_addr = i_cmd.pull_rd ? ref_addr : fill_addr;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_mem_q <= mem[rd_addr];
        end
    end

    assign rcol_last = (r_rcol == COL_MAX);
    assign page_last = (r_page == PAGE_MAX);

    always_comb begin
        n_out_cmd = (r_hdr != HDR_DATA);
        n_out_end = (r_hdr == HDR_DATA) && rcol_last && page_last;
        case (r_hdr)
            HDR_PAGE:   n_out_byte = CMD_PAGE_BASE + 8'(r_page);
            HDR_COL_LO: n_out_byte = CMD_COL_LOW;
            HDR_COL_HI: n_out_byte = CMD_COL_HIGH;
            HDR_DATA:   n_out_byte = r_mem_q;
            default:    n_out_byte = r_mem_q;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_x0 <= CW'(i_x);
            r_x1 <= CW'(xe_c9);
            r_y0 <= RW'(i_y);
            r_y1 <= RW'(ye_c9);
            r_g1 <= PW'(ye_c9 >> 3);
            r_on <= i_pixel_on;
        end
        if (i_cmd.emit) begin
            r_out_cmd  <= n_out_cmd;
            r_out_byte <= n_out_byte;
            r_out_end  <= n_out_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col       <= '0;
            r_grp       <= '0;
            r_clr_addr  <= '0;
            r_active    <= 1'b0;
            r_page      <= '0;
            r_hdr       <= HDR_PAGE;
            r_rcol      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_col <= CW'(i_x);
                r_grp <= PW'(i_y >> 3);
            end else if (i_cmd.fill_wr) begin
                if (r_col == r_x1) begin
                    r_col <= r_x0;
                    r_grp <= r_grp + 1'b1;
                end else begin
                    r_col <= r_col + 1'b1;
                end
            end

            if (i_cmd.clr_start) begin
                r_clr_addr <= '0;
            end else if (i_cmd.clr_wr) begin
                r_clr_addr <= (r_clr_addr == ADDR_MAX) ? '0 : r_clr_addr + 1'b1;
            end

            if (i_cmd.start_refresh) begin
                r_active <= 1'b1;
                r_page   <= '0;
                r_hdr    <= HDR_PAGE;
                r_rcol   <= '0;
            end else if (i_cmd.emit) begin
                if (r_hdr != HDR_DATA) begin
                    r_hdr <= r_hdr + 1'b1;
                end else if (rcol_last) begin
                    r_hdr  <= HDR_PAGE;
                    r_rcol <= '0;
                    if (page_last) begin
                        r_page   <= '0;
                        r_active <= 1'b0;
                    end else begin
                        r_page <= r_page + 1'b1;
                    end
                end else begin
                    r_rcol <= r_rcol + 1'b1;
                end
            end

            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_sts.box_empty      = ({1'b0, i_x} > xe_c9) || ({1'b0, i_y} > ye_c9);
    assign o_sts.fill_last      = (r_col == r_x1) && (r_grp == r_g1);
    assign o_sts.clr_last       = (r_clr_addr == ADDR_MAX);
    assign o_sts.refresh_active = r_active;
    assign o_sts.hdr_data       = (r_hdr == HDR_DATA);
    assign o_sts.out_free       = !r_out_valid || i_out_ready;

    assign o_out_valid  = r_out_valid;
    assign o_is_command = r_out_cmd;
    assign o_byte_value = r_out_byte;
    assign o_frame_end  = r_out_end;

    a_one_writer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({i_cmd.clr_wr, i_cmd.fill_wr}))
        else $error("clear sweep and box walk write the store together");

    a_end_stops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.emit && n_out_end) |=> !r_active)
        else $error("refresh still active after the frame end item");

    a_end_is_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_end) |-> !r_out_cmd)
        else $error("frame end flagged on a command byte");

endmodule

// ===== rtl/mono_display_framebuffer_top.sv =====
// Top level of the mono display frame store with page-mode refresh output.
// Depends on mdf_pkg, mdf_ctrl and mdf_datapath.
//
//  channel | handshake                  | payload
//  --------+----------------------------+----------------------------------------
//  in      | i_in_valid / o_in_ready    | i_operation i_x i_y i_x_end i_y_end
//          |                            | i_pixel_on
//  out     | o_out_valid / i_out_ready  | o_is_command o_byte_value o_frame_end
//
// One item at a time. Start refresh, idle pulls and unused codes end at their accept;
// a point write steps through accept, store read and store write, and ends at its accept
// when off screen; a rectangle fill is the accept and then a store read and a store write
// per byte covered; a clear is the accept and then a sweep of COLUMNS*PAGES store writes;
// a pull is the accept and an emit for a command byte, and the accept, a store read and an
// emit for a data byte. After reset a clearing pass writes all COLUMNS*PAGES store bytes
// with o_in_ready low. A stalled output holds only pulls; other items proceed.
module mono_display_framebuffer_top #(
    parameter int COLUMNS = 128,
    parameter int PAGES   = 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  mdf_pkg::t_op  i_operation,
    input  logic [7:0]    i_x,
    input  logic [7:0]    i_y,
    input  logic [7:0]    i_x_end,
    input  logic [7:0]    i_y_end,
    input  logic          i_pixel_on,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output logic          o_is_command,
    output logic [7:0]    o_byte_value,
    output logic          o_frame_end
);
    import mdf_pkg::*;

    t_cmd cmd;
    t_sts sts;

    mdf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_operation (i_operation),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    mdf_datapath #(
        .COLUMNS (COLUMNS),
        .PAGES   (PAGES)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_operation  (i_operation),
        .i_x          (i_x),
        .i_y          (i_y),
        .i_x_end      (i_x_end),
        .i_y_end      (i_y_end),
        .i_pixel_on   (i_pixel_on),
        .i_out_ready  (i_out_ready),
        .o_out_valid  (o_out_valid),
        .o_is_command (o_is_command),
        .o_byte_value (o_byte_value),
        .o_frame_end  (o_frame_end)
    );

endmodule
